### rtl/nibble_masked_pattern_scanner_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the nibble masked pattern scanner
// Shared forms for same-cycle and next-cycle checks on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef NIBBLE_MASKED_PATTERN_SCANNER_MACROS_SVH
`define NIBBLE_MASKED_PATTERN_SCANNER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define NMPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nmps same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define NMPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nmps next-cycle check failed");

`endif

### rtl/nmps_pkg.sv
// ---------------------------------------------------------------------------
// nmps_pkg
// Types and constants shared by the pattern scanner modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nmps_pkg;

  localparam int unsigned PAT_REG_BYTES = 16;
  localparam int unsigned PAT_BITS      = 8 * PAT_REG_BYTES;
  localparam int unsigned PICK_W        = 4;
  localparam int unsigned ADDR_W        = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned PLEN_W        = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VALUE_LO = 3'd0,
    CFG_VALUE_HI = 3'd1,
    CFG_MASK_LO  = 3'd2,
    CFG_MASK_HI  = 3'd3,
    CFG_LENGTH   = 3'd4,
    CFG_BASE     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } res_t;

endpackage

### rtl/nmps_cell.sv
// ---------------------------------------------------------------------------
// nmps_cell
// One window byte: holds it, passes it on, and compares the incoming byte
// against the pattern byte that lines up with this position.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmps_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned LEN_W = 5
) (
  input  logic                          clk,
  input  logic                          shift_en,
  input  logic [7:0]                    byte_i,
  input  logic [LEN_W-1:0]              len_i,
  input  logic [nmps_pkg::PAT_BITS-1:0] pat_value_i,
  input  logic [nmps_pkg::PAT_BITS-1:0] pat_mask_i,
  output logic [7:0]                    byte_o,
  output logic                          hit_o
);
  import nmps_pkg::*;

  localparam logic [LEN_W-1:0] IDX = LEN_W'(INDEX);

  logic [7:0]        byte_r;
  logic [LEN_W-1:0]  sel;
  logic [PICK_W-1:0] pick;
  logic              active;
  logic              in_regs;
  logic [7:0]        pv;
  logic [7:0]        pm;

  // Pattern byte len-1-INDEX meets this position; bytes past the registers are wildcards.
  always_comb begin
    active  = IDX < len_i;
    sel     = len_i - IDX - LEN_W'(1);
    in_regs = sel < PAT_REG_BYTES;
    pick    = PICK_W'(sel);
    pv      = pat_value_i[pick*8 +: 8];
    pm      = pat_mask_i[pick*8 +: 8];
    hit_o   = !active || !in_regs || (((byte_i ^ pv) & pm) == 8'h00);
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_i;
    end
  end

  assign byte_o = byte_r;

endmodule

### rtl/nmps_out_stage.sv
// ---------------------------------------------------------------------------
// nmps_out_stage
// Result register: holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmps_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load_i,
  input  nmps_pkg::res_t res_i,
  input  logic           out_ready_i,
  output logic           ready_o,
  output logic           out_valid_o,
  output nmps_pkg::res_t res_o
);
  import nmps_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // Free when empty or when the held result leaves this cycle.
  assign ready_o = !valid_r || out_ready_i;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_ready_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid_o = valid_r;
  assign res_o       = res_r;

endmodule

### rtl/nibble_masked_pattern_scanner.sv
// ---------------------------------------------------------------------------
// nibble_masked_pattern_scanner
// Finds the first place in a byte stream where a masked pattern matches.
// ---------------------------------------------------------------------------
//  channel  | direction | transfer carries
//  ---------+-----------+------------------------------------------------
//  in_      | slave     | tdata[7:0] data byte, tlast final byte of range
//  out_     | master    | tdata[63:0] match address, tuser[0] found
//  cfg_     | slave     | cfg_index register index, cfg_data write value
//
//  One byte a cycle when not stalled: the new byte and window cells are
//  compared in the same cycle and the result lands in the output register
//  on the next edge. The figure is set by the parallel compare of the row.
//  rst_n (synchronous) clears scan state, result valid and the config
//  registers; pattern_length resets to 1.
//  A stalled result blocks input only while the output register is full and
//  its transfer is not taken in that cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nibble_masked_pattern_scanner #(
  parameter int unsigned PATTERN_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [7:0] data_byte
  input  logic [7:0]                     in_tdata,
  input  logic                           in_tlast,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_tdata: [63:0] match_address
  output logic [nmps_pkg::ADDR_W-1:0]    out_tdata,
  // out_tuser: [0] found
  output logic [0:0]                     out_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nmps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);
  import nmps_pkg::*;

`include "nibble_masked_pattern_scanner_macros.svh"

  localparam int unsigned LEN_W = $clog2(PATTERN_BYTES + 1);
  localparam int unsigned CMP_W = (LEN_W > PLEN_W) ? LEN_W : PLEN_W;

  // Configuration registers
  logic [PAT_BITS-1:0] pat_value_r;
  logic [PAT_BITS-1:0] pat_mask_r;
  logic [PLEN_W-1:0]   pat_len_r;
  logic [ADDR_W-1:0]   scan_base_r;

  // Scan state
  logic [LEN_W-1:0]    seen_r;
  logic [LEN_W-1:0]    seen_nxt;
  logic [ADDR_W-1:0]   offset_r;
  logic [ADDR_W-1:0]   offset_nxt;
  logic                reported_r;
  logic                reported_nxt;

  logic                accept;
  logic                stage_ready;
  logic [CMP_W-1:0]    plen_ext;
  logic [LEN_W-1:0]    len_eff;
  logic [7:0]          chain [PATTERN_BYTES+1];
  logic [PATTERN_BYTES-1:0] hits;
  logic                match_now;
  logic                fire;
  res_t                res_in;
  res_t                res_out;

  assign cfg_ready = 1'b1;
  assign in_tready = stage_ready;
  assign accept    = in_tvalid && in_tready;

  // Config writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_value_r <= '0;
      pat_mask_r  <= '0;
      pat_len_r   <= PLEN_W'(1);
      scan_base_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_VALUE_LO: pat_value_r[63:0]   <= cfg_data;
        CFG_VALUE_HI: pat_value_r[127:64] <= cfg_data;
        CFG_MASK_LO:  pat_mask_r[63:0]    <= cfg_data;
        CFG_MASK_HI:  pat_mask_r[127:64]  <= cfg_data;
        CFG_LENGTH:   pat_len_r           <= cfg_data[PLEN_W-1:0];
        CFG_BASE:     scan_base_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the length: zero counts as one, anything past the window as full.
  always_comb begin
    plen_ext = CMP_W'(pat_len_r);
    if (plen_ext == '0) begin
      len_eff = LEN_W'(1);
    end else if (plen_ext > CMP_W'(PATTERN_BYTES)) begin
      len_eff = LEN_W'(PATTERN_BYTES);
    end else begin
      len_eff = LEN_W'(plen_ext);
    end
  end

  // Row of window cells; cell 0 holds the latest byte taken, cell k the byte k transfers before it.
  assign chain[0] = in_tdata;

  for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
    nmps_cell #(
      .INDEX(k),
      .LEN_W(LEN_W)
    ) u_cell (
      .clk        (clk),
      .shift_en   (accept),
      .byte_i     (chain[k]),
      .len_i      (len_eff),
      .pat_value_i(pat_value_r),
      .pat_mask_i (pat_mask_r),
      .byte_o     (chain[k+1]),
      .hit_o      (hits[k])
    );
  end

  // Match on the window as it stands once this byte is in.
  always_comb begin
    seen_nxt = (seen_r < LEN_W'(PATTERN_BYTES)) ? seen_r + LEN_W'(1) : seen_r;
    match_now = !reported_r && (seen_nxt >= len_eff) && (&hits);
    fire = accept && (match_now || (in_tlast && !reported_r));
    res_in.found = match_now;
    res_in.match_address = match_now
        ? scan_base_r + offset_r - ADDR_W'(len_eff - LEN_W'(1))
        : '0;
  end

  // Advance the scan; the final byte clears it for the next range.
  always_comb begin
    offset_nxt   = offset_r;
    reported_nxt = reported_r;
    if (accept) begin
      if (in_tlast) begin
        offset_nxt   = '0;
        reported_nxt = 1'b0;
      end else begin
        offset_nxt   = offset_r + ADDR_W'(1);
        reported_nxt = reported_r || match_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      offset_r   <= '0;
      reported_r <= 1'b0;
    end else begin
      if (accept) begin
        seen_r <= in_tlast ? '0 : seen_nxt;
      end
      offset_r   <= offset_nxt;
      reported_r <= reported_nxt;
    end
  end

  nmps_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (fire),
    .res_i      (res_in),
    .out_ready_i(out_tready),
    .ready_o    (stage_ready),
    .out_valid_o(out_tvalid),
    .res_o      (res_out)
  );

  assign out_tdata    = res_out.match_address;
  assign out_tuser[0] = res_out.found;

  `NMPS_ASSERT_NOW(a_no_overrun, fire, stage_ready)
  `NMPS_ASSERT_NEXT(a_report_once, accept && match_now && !in_tlast, reported_r)
  `NMPS_ASSERT_NEXT(a_range_clear, accept && in_tlast,
                    seen_r == '0 && offset_r == '0 && !reported_r)
  `NMPS_ASSERT_NOW(a_notfound_zero, out_tvalid && !out_tuser[0], out_tdata == '0)

endmodule
